/* rtl/gpms_pkg.sv */
// Shared types, constants and helper functions for the greedy point-match scorer.
// Used by gpms_ctrl, gpms_datapath and greedy_point_match_scoring; depends on nothing.
`default_nettype none

package gpms_pkg;

    // Store size and coordinate format (signed Q7.16 metres).
    localparam int PRED_DEPTH = 256;
    localparam int COORD_BITS = 24;

    // Field widths.
    localparam int MODE_W = 2;
    localparam int OID_W  = 8;
    localparam int TOL_W  = 23;
    localparam int NOBJ_W = 9;
    localparam int FRM_W  = 9;
    localparam int FN_W   = 16;
    localparam int TOT_W  = 32;

    // Derived widths.
    localparam int AW      = (PRED_DEPTH > 1) ? $clog2(PRED_DEPTH) : 1;
    localparam int CNT_W   = $clog2(PRED_DEPTH + 1);
    localparam int CNTX_W  = (CNT_W > FRM_W) ? CNT_W : FRM_W;
    localparam int CMP_W   = (COORD_BITS > TOL_W) ? COORD_BITS : TOL_W;
    localparam int SQ_W    = 2 * TOL_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int CFG_W   = (TOL_W > NOBJ_W) ? TOL_W : NOBJ_W;
    localparam int CFG_IDX_W = 1;

    localparam int IN_BITS      = OID_W + 3 * COORD_BITS;
    localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = 2 * FRM_W + FN_W + 3 * TOT_W + 1;
    localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // Saturation limits and reset values of the configuration registers.
    localparam logic [FRM_W-1:0]  FRM_MAX    = '1;
    localparam logic [FN_W-1:0]   FN_MAX     = '1;
    localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(4588);
    localparam logic [NOBJ_W-1:0] NOBJ_RESET = NOBJ_W'(2);

    // Request kinds carried in tuser.
    typedef enum logic [MODE_W-1:0] {
        MODE_PRED  = 2'd0,
        MODE_GT    = 2'd1,
        MODE_EOF   = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE   = 1'b0,
        CFG_NUM_OBJECTS = 1'b1
    } t_cfg_idx;

    // One point; x sits in the lowest bits.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_point;

    // One result; frame_true_pos sits in the lowest bits.
    typedef struct packed {
        logic              overflow;
        logic [TOT_W-1:0]  total_false_pos;
        logic [TOT_W-1:0]  total_false_neg;
        logic [TOT_W-1:0]  total_true_pos;
        logic [FRM_W-1:0]  frame_false_pos;
        logic [FN_W-1:0]   frame_false_neg;
        logic [FRM_W-1:0]  frame_true_pos;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_pred;
        logic scan_start;
        logic scan_run;
        logic end_frame;
        logic clear_totals;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic gt_counted;
        logic out_free;
    } t_status;

    // Magnitude of the difference of two coordinates.
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] nd;
        d  = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        nd = ~d + 1'b1;
        return d[COORD_BITS] ? nd[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    endfunction

    // Clamp a store-sized count to a frame count field.
    function automatic logic [FRM_W-1:0] sat_frame(input logic [CNT_W-1:0] v);
        logic [CNTX_W-1:0] w;
        w = CNTX_W'(v);
        return (w > CNTX_W'(FRM_MAX)) ? FRM_MAX : w[FRM_W-1:0];
    endfunction

    // Saturating add for the running totals.
    function automatic logic [TOT_W-1:0] sat_add(
        input logic [TOT_W-1:0] a,
        input logic [TOT_W-1:0] b
    );
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/gpms_ctrl.sv */
// Controller of the point-match scorer: request acceptance and the scan state machine.
// Depends on gpms_pkg; drives the command struct consumed by gpms_datapath.
`default_nettype none

module gpms_ctrl (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_axis_tvalid,
    input  wire  [gpms_pkg::MODE_W-1:0]   i_mode,
    input  gpms_pkg::t_status             i_status,
    output logic                          o_s_axis_tready,
    output gpms_pkg::t_cmd                o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state          r_state;
    t_state          n_state;
    gpms_pkg::t_mode w_mode;
    logic            w_accept;

    assign w_mode = gpms_pkg::t_mode'(i_mode);

    // An end-of-frame request waits until the result register can take it.
    assign o_s_axis_tready = (r_state == S_IDLE) &&
                             ((w_mode != gpms_pkg::MODE_EOF) || i_status.out_free);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Decode accepted requests into datapath commands.
    always_comb begin
        o_cmd              = '0;
        o_cmd.scan_run     = (r_state == S_SCAN);
        if (w_accept) begin
            unique case (w_mode)
                gpms_pkg::MODE_PRED:  o_cmd.store_pred   = 1'b1;
                gpms_pkg::MODE_GT:    o_cmd.scan_start   = i_status.gt_counted;
                gpms_pkg::MODE_EOF:   o_cmd.end_frame    = 1'b1;
                gpms_pkg::MODE_CLEAR: o_cmd.clear_totals = 1'b1;
            endcase
        end
    end

    // Next state: a counted ground-truth point starts a scan of the store.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.scan_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/gpms_datapath.sv */
// Datapath of the point-match scorer: prediction store, match pipeline, counters, result register.
// Depends on gpms_pkg; driven by the command struct from gpms_ctrl.
`default_nettype none

module gpms_datapath (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  gpms_pkg::t_cmd                    i_cmd,
    input  wire  [gpms_pkg::OID_W-1:0]        i_oid,
    input  gpms_pkg::t_point                  i_point,
    input  wire                               i_cfg_we,
    input  wire  [gpms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [gpms_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire                               i_m_tready,
    output gpms_pkg::t_status                 o_status,
    output logic                              o_m_tvalid,
    output gpms_pkg::t_result                 o_result
);

    localparam int AW    = gpms_pkg::AW;
    localparam int CNT_W = gpms_pkg::CNT_W;
    localparam int TOL_W = gpms_pkg::TOL_W;
    localparam int CMP_W = gpms_pkg::CMP_W;
    localparam int SQ_W  = gpms_pkg::SQ_W;
    localparam int SUM_W = gpms_pkg::SUM_W;

    // Configuration registers and the squared radius.
    logic [TOL_W-1:0]            r_tol;
    logic [gpms_pkg::NOBJ_W-1:0] r_num_obj;
    logic [SQ_W-1:0]             r_tol_sq;

    // Prediction store and per-entry assigned marks.
    gpms_pkg::t_point                r_mem [gpms_pkg::PRED_DEPTH];
    logic                            r_marks [gpms_pkg::PRED_DEPTH];
    logic [CNT_W-1:0]                r_pred_cnt;
    logic                            r_overflow;

    // Frame counters and running totals.
    logic [CNT_W-1:0]              r_match_cnt;
    logic [gpms_pkg::FN_W-1:0]     r_fn_cnt;
    logic [gpms_pkg::TOT_W-1:0]    r_tot_tp;
    logic [gpms_pkg::TOT_W-1:0]    r_tot_fn;
    logic [gpms_pkg::TOT_W-1:0]    r_tot_fp;

    // Scan pipeline: read, axis check, square, sum and compare.
    gpms_pkg::t_point  r_pt;
    logic [CNT_W-1:0]  r_scan_idx;
    gpms_pkg::t_point  r_rd;
    logic              r_s1_vld;
    logic [AW-1:0]     r_s1_idx;
    logic              r_s1_free;
    logic              r_s2_vld;
    logic [AW-1:0]     r_s2_idx;
    logic              r_s2_cand;
    logic [TOL_W-1:0]  r_s2_abs [3];
    logic              r_s3_vld;
    logic [AW-1:0]     r_s3_idx;
    logic              r_s3_cand;
    logic [SQ_W-1:0]   r_s3_sq [3];

    // Result register.
    logic              r_out_vld;
    gpms_pkg::t_result r_out;

    logic                       w_full;
    logic                       w_store;
    logic                       w_more;
    logic                       w_issue;
    logic                       w_hit;
    logic                       w_done;
    logic [SUM_W-1:0]           w_sum;
    logic [CMP_W-1:0]           w_abs [3];
    logic                       w_near;
    logic [gpms_pkg::NOBJ_W-1:0] w_oid_next;
    logic [gpms_pkg::FRM_W-1:0] w_tp;
    logic [gpms_pkg::FRM_W-1:0] w_fp;
    logic [CNT_W-1:0]           w_unassigned;

    assign w_full  = (r_pred_cnt == CNT_W'(gpms_pkg::PRED_DEPTH));
    assign w_store = i_cmd.store_pred && !w_full;

    // Ground truth counts only below the highest object id.
    assign w_oid_next          = gpms_pkg::NOBJ_W'(i_oid) + 1'b1;
    assign o_status.gt_counted = (w_oid_next < r_num_obj);
    assign o_status.out_free   = !r_out_vld || i_m_tready;

    // Configuration writes; the squared radius is registered from the radius in the cycle after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol     <= gpms_pkg::TOL_RESET;
            r_num_obj <= gpms_pkg::NOBJ_RESET;
        end else if (i_cfg_we) begin
            unique case (gpms_pkg::t_cfg_idx'(i_cfg_idx))
                gpms_pkg::CFG_TOLERANCE:   r_tol     <= i_cfg_data[TOL_W-1:0];
                gpms_pkg::CFG_NUM_OBJECTS: r_num_obj <= i_cfg_data[gpms_pkg::NOBJ_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_tol_sq <= r_tol * r_tol;
    end

    // Store writes and the scan read port.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_pred_cnt[AW-1:0]] <= i_point;
        end
        if (w_issue) begin
            r_rd <= r_mem[r_scan_idx[AW-1:0]];
        end
    end

    // Assigned marks: a newly stored prediction starts free and a match claims it.
    // Only entries below the fill count are ever read, so no clearing is needed.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_marks[r_pred_cnt[AW-1:0]] <= 1'b0;
        end else if (w_hit) begin
            r_marks[r_s3_idx] <= 1'b1;
        end
    end

    // While a scan runs, issue one stored prediction per cycle until a match is found or the store is used up.
    assign w_more  = (r_scan_idx < r_pred_cnt);
    assign w_issue = i_cmd.scan_run && !w_hit && w_more;

    // Per-axis distance and the early reject on any far axis.
    always_comb begin
        w_abs[0] = CMP_W'(gpms_pkg::abs_diff(r_pt.x, r_rd.x));
        w_abs[1] = CMP_W'(gpms_pkg::abs_diff(r_pt.y, r_rd.y));
        w_abs[2] = CMP_W'(gpms_pkg::abs_diff(r_pt.z, r_rd.z));
        w_near   = (w_abs[0] < CMP_W'(r_tol)) && (w_abs[1] < CMP_W'(r_tol)) &&
                   (w_abs[2] < CMP_W'(r_tol));
    end

    // Sum of squares against the squared radius.
    assign w_sum  = SUM_W'(r_s3_sq[0]) + SUM_W'(r_s3_sq[1]) + SUM_W'(r_s3_sq[2]);
    assign w_hit  = i_cmd.scan_run && r_s3_vld && r_s3_cand && (w_sum < SUM_W'(r_tol_sq));
    assign w_done = i_cmd.scan_run &&
                    (w_hit || (!w_more && !r_s1_vld && !r_s2_vld && !r_s3_vld));
    assign o_status.scan_done = w_done;

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_pt <= i_point;
        end
        r_s1_idx  <= r_scan_idx[AW-1:0];
        r_s1_free <= !r_marks[r_scan_idx[AW-1:0]];
        r_s2_idx  <= r_s1_idx;
        r_s2_cand <= r_s1_free && w_near;
        for (int i = 0; i < 3; i++) begin
            r_s2_abs[i] <= w_abs[i][TOL_W-1:0];
            r_s3_sq[i]  <= r_s2_abs[i] * r_s2_abs[i];
        end
        r_s3_idx  <= r_s2_idx;
        r_s3_cand <= r_s2_cand;
    end

    // Pipeline control; a match flushes the predictions still in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
            end else if (w_issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (!i_cmd.scan_run || w_hit) begin
                r_s1_vld <= 1'b0;
                r_s2_vld <= 1'b0;
                r_s3_vld <= 1'b0;
            end else begin
                r_s1_vld <= w_issue;
                r_s2_vld <= r_s1_vld;
                r_s3_vld <= r_s2_vld;
            end
        end
    end

    // Frame values; every match takes a distinct stored prediction.
    assign w_unassigned = r_pred_cnt - r_match_cnt;
    assign w_tp         = gpms_pkg::sat_frame(r_match_cnt);
    assign w_fp         = gpms_pkg::sat_frame(w_unassigned);

    // Frame state: store fill, counters and the overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred_cnt  <= '0;
            r_overflow  <= 1'b0;
            r_match_cnt <= '0;
            r_fn_cnt    <= '0;
        end else if (i_cmd.end_frame) begin
            r_pred_cnt  <= '0;
            r_overflow  <= 1'b0;
            r_match_cnt <= '0;
            r_fn_cnt    <= '0;
        end else begin
            if (w_store) begin
                r_pred_cnt <= r_pred_cnt + 1'b1;
            end else if (i_cmd.store_pred) begin
                r_overflow <= 1'b1;
            end
            if (w_hit) begin
                r_match_cnt <= r_match_cnt + 1'b1;
            end else if (w_done && (r_fn_cnt != gpms_pkg::FN_MAX)) begin
                r_fn_cnt <= r_fn_cnt + 1'b1;
            end
        end
    end

    // Running totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_totals) begin
            r_tot_tp <= '0;
            r_tot_fn <= '0;
            r_tot_fp <= '0;
        end else if (i_cmd.end_frame) begin
            r_tot_tp <= gpms_pkg::sat_add(r_tot_tp, gpms_pkg::TOT_W'(w_tp));
            r_tot_fn <= gpms_pkg::sat_add(r_tot_fn, gpms_pkg::TOT_W'(r_fn_cnt));
            r_tot_fp <= gpms_pkg::sat_add(r_tot_fp, gpms_pkg::TOT_W'(w_fp));
        end
    end

    // Result register, loaded at the end of a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.end_frame) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.end_frame) begin
            r_out.frame_true_pos  <= w_tp;
            r_out.frame_false_neg <= r_fn_cnt;
            r_out.frame_false_pos <= w_fp;
            r_out.total_true_pos  <= gpms_pkg::sat_add(r_tot_tp, gpms_pkg::TOT_W'(w_tp));
            r_out.total_false_neg <= gpms_pkg::sat_add(r_tot_fn, gpms_pkg::TOT_W'(r_fn_cnt));
            r_out.total_false_pos <= gpms_pkg::sat_add(r_tot_fp, gpms_pkg::TOT_W'(w_fp));
            r_out.overflow        <= r_overflow;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_result   = r_out;

    // A match only ever takes a prediction that is still free.
    a_hit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> !r_marks[r_s3_idx])
        else $error("match on an assigned prediction");

    // The fill count never passes the store depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pred_cnt <= CNT_W'(gpms_pkg::PRED_DEPTH))
        else $error("prediction count beyond store depth");

    // Matches never outnumber the stored predictions.
    a_match_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match_cnt <= r_pred_cnt)
        else $error("more matches than stored predictions");

    // A frame result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.end_frame |-> (!r_out_vld || i_m_tready))
        else $error("frame result overwritten");

endmodule

`default_nettype wire

/* rtl/greedy_point_match_scoring.sv */
// Top level of the greedy point-match scorer: stream ports, configuration port, wiring.
// Depends on gpms_pkg, gpms_ctrl and gpms_datapath.
//
//  Channel   Direction  Handshake           Contents
//  s_axis    in         tvalid / tready     tuser: mode; tdata: object_id, x, y, z
//  m_axis    out        tvalid / tready     tdata: frame and total counts, overflow
//  cfg       in         i_cfg_we only       register index and write data, no read-back
//
// A counted ground-truth request scans the store one prediction per cycle through its
// single read port, and each prediction passes the four-stage read / axis check / square /
// sum-compare pipeline; a match ends the scan early, and no request is taken during a scan.
// Synchronous active-low reset empties the store, clears counts and totals and drops any waiting result.
// A waiting result holds back only end-of-frame requests; other requests are still taken.
`default_nettype none

module greedy_point_match_scoring (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // s_axis tdata, low to high: object_id[7:0], x[31:8], y[55:32], z[79:56]
    input  wire  [gpms_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // s_axis tuser: mode[1:0]
    input  wire  [gpms_pkg::MODE_W-1:0]         i_s_axis_tuser,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // m_axis tdata, low to high: frame_true_pos, frame_false_neg, frame_false_pos,
    // total_true_pos, total_false_neg, total_false_pos, overflow, zero padding
    output logic [gpms_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    input  wire                                 i_cfg_we,
    input  wire  [gpms_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [gpms_pkg::CFG_W-1:0]          i_cfg_data
);

    gpms_pkg::t_cmd    w_cmd;
    gpms_pkg::t_status w_status;
    gpms_pkg::t_point  w_point;
    gpms_pkg::t_result w_result;

    assign w_point = i_s_axis_tdata[gpms_pkg::OID_W +: 3 * gpms_pkg::COORD_BITS];

    gpms_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_mode          (i_s_axis_tuser),
        .i_status        (w_status),
        .o_s_axis_tready (o_s_axis_tready),
        .o_cmd           (w_cmd)
    );

    gpms_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_oid      (i_s_axis_tdata[gpms_pkg::OID_W-1:0]),
        .i_point    (w_point),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (i_m_axis_tready),
        .o_status   (w_status),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_result   (w_result)
    );

    assign o_m_axis_tdata = gpms_pkg::OUT_DATA_W'(w_result);

endmodule

`default_nettype wire

/* sim/gpms_checker.sv */
// Scoreboard for the greedy point-match scorer: mirrors the per-frame matching,
// predicts every end-of-frame report and compares it with the output stream.
// Depends on gpms_pkg only; instantiated beside the block by the testbench top.
module gpms_checker (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // s_axis tdata, low to high: object_id, x, y, z
    input  wire  [gpms_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // s_axis tuser: mode
    input  wire  [gpms_pkg::MODE_W-1:0]       i_s_tuser,
    input  wire                               i_s_tvalid,
    input  wire                               i_s_tready,
    // m_axis tdata, low to high: frame counts, running totals, overflow, padding
    input  wire  [gpms_pkg::OUT_DATA_W-1:0]   i_m_tdata,
    input  wire                               i_m_tvalid,
    input  wire                               i_m_tready,
    input  wire                               i_cfg_we,
    input  wire  [gpms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [gpms_pkg::CFG_W-1:0]        i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_reports,
    output int                                o_overflow_reports,
    output int                                o_saturated_reports
);
    timeunit 1ns;
    timeprecision 1ps;

    import gpms_pkg::*;

    // Mirror of the frame state: stored predictions and their claimed marks.
    t_point            pred_pts [PRED_DEPTH];
    bit                pred_taken [PRED_DEPTH];
    int                pred_total = 0;
    logic [FRM_W-1:0]  hits = '0;
    logic [FN_W-1:0]   misses = '0;
    logic [TOT_W-1:0]  sum_tp = '0;
    logic [TOT_W-1:0]  sum_fn = '0;
    logic [TOT_W-1:0]  sum_fp = '0;
    bit                dropped = 1'b0;

    // Mirror of the configuration registers.
    logic [TOL_W-1:0]  radius = TOL_RESET;
    logic [NOBJ_W-1:0] class_count = NOBJ_RESET;

    // Reports still owed by the block, oldest first.
    t_result           owed_reports_q [$];
    int                fails = 0;
    int                seen_reports = 0;
    int                seen_overflow = 0;
    int                seen_saturated = 0;

    // A point matches when every axis gap is below the radius and the squared
    // distance is below the squared radius; all of it is exact in 64 bits.
    function automatic bit within_radius(t_point a, t_point b, logic [TOL_W-1:0] r);
        longint gap [3];
        longint mag;
        longint dist2;
        longint r64;
        int     k;
        gap[0] = longint'($signed(a.x)) - longint'($signed(b.x));
        gap[1] = longint'($signed(a.y)) - longint'($signed(b.y));
        gap[2] = longint'($signed(a.z)) - longint'($signed(b.z));
        r64    = longint'(r);
        dist2  = 0;
        for (k = 0; k < 3; k++) begin
            mag = (gap[k] < 0) ? -gap[k] : gap[k];
            if (mag >= r64) begin
                return 1'b0;
            end
            dist2 += mag * mag;
        end
        return dist2 < r64 * r64;
    endfunction

    // Running totals stick at all ones instead of wrapping.
    function automatic logic [TOT_W-1:0] add_clamped(logic [TOT_W-1:0] a,
                                                     logic [TOT_W-1:0] b);
        if (a > ~b) begin
            return '1;
        end
        return a + b;
    endfunction

    // A counted ground-truth point claims the first free prediction in range.
    task automatic score_truth(t_point gt);
        int k;
        bit found;
        found = 1'b0;
        for (k = 0; k < pred_total && !found; k++) begin
            if (!pred_taken[k] && within_radius(gt, pred_pts[k], radius)) begin
                pred_taken[k] = 1'b1;
                found = 1'b1;
            end
        end
        if (found) begin
            if (hits != FRM_MAX) begin
                hits++;
            end
        end else if (misses != FN_MAX) begin
            misses++;
        end
    endtask

    // End of frame: the report is owed, the totals advance and the store empties.
    task automatic close_frame();
        t_result rep;
        int      k;
        int      unclaimed;
        unclaimed = 0;
        for (k = 0; k < pred_total; k++) begin
            if (!pred_taken[k]) begin
                unclaimed++;
            end
        end
        rep.frame_true_pos  = hits;
        rep.frame_false_neg = misses;
        rep.frame_false_pos = (unclaimed > int'(FRM_MAX)) ? FRM_MAX : FRM_W'(unclaimed);
        sum_tp = add_clamped(sum_tp, TOT_W'(rep.frame_true_pos));
        sum_fn = add_clamped(sum_fn, TOT_W'(rep.frame_false_neg));
        sum_fp = add_clamped(sum_fp, TOT_W'(rep.frame_false_pos));
        rep.total_true_pos  = sum_tp;
        rep.total_false_neg = sum_fn;
        rep.total_false_pos = sum_fp;
        rep.overflow        = dropped;
        owed_reports_q = {owed_reports_q, rep};
        pred_total = 0;
        hits       = '0;
        misses     = '0;
        dropped    = 1'b0;
    endtask

    // Apply one accepted input request to the mirror.
    task automatic take_request(t_mode kind, logic [IN_DATA_W-1:0] word);
        logic [OID_W-1:0] oid;
        t_point           pt;
        oid = word[OID_W-1:0];
        pt  = word[OID_W +: 3*COORD_BITS];
        case (kind)
            MODE_PRED: begin
                if (pred_total < PRED_DEPTH) begin
                    pred_pts[pred_total]   = pt;
                    pred_taken[pred_total] = 1'b0;
                    pred_total++;
                end else begin
                    dropped = 1'b1;
                end
            end
            MODE_GT: begin
                if (int'(oid) + 1 < int'(class_count)) begin
                    score_truth(pt);
                end
            end
            MODE_EOF: begin
                close_frame();
            end
            MODE_CLEAR: begin
                sum_tp = '0;
                sum_fn = '0;
                sum_fp = '0;
            end
        endcase
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            fails++;
            if (fails <= 10) begin
                $display("gpms_checker: report %0d %s expected %0d got %0d",
                         seen_reports, name, want, got);
            end
        end
    endtask

    // Compare an accepted report with the oldest one owed.
    task automatic check_report(logic [OUT_DATA_W-1:0] word);
        t_result got;
        t_result want;
        got = word[OUT_BITS-1:0];
        seen_reports++;
        if (got.overflow) begin
            seen_overflow++;
        end
        if (owed_reports_q.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("gpms_checker: report %0d arrived with none owed: %h",
                         seen_reports, word);
            end
            return;
        end
        want = owed_reports_q.pop_front();
        if (want.frame_false_neg == FN_MAX) begin
            seen_saturated++;
        end
        compare_field("frame_true_pos",  want.frame_true_pos,  got.frame_true_pos);
        compare_field("frame_false_neg", want.frame_false_neg, got.frame_false_neg);
        compare_field("frame_false_pos", want.frame_false_pos, got.frame_false_pos);
        compare_field("total_true_pos",  want.total_true_pos,  got.total_true_pos);
        compare_field("total_false_neg", want.total_false_neg, got.total_false_neg);
        compare_field("total_false_pos", want.total_false_pos, got.total_false_pos);
        compare_field("overflow",        want.overflow,        got.overflow);
        compare_field("padding",         0,                    word[OUT_DATA_W-1:OUT_BITS]);
    endtask

    // Outputs are taken before this edge's request so a report never meets its own frame.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pred_total  = 0;
            hits        = '0;
            misses      = '0;
            sum_tp      = '0;
            sum_fn      = '0;
            sum_fp      = '0;
            dropped     = 1'b0;
            radius      = TOL_RESET;
            class_count = NOBJ_RESET;
            owed_reports_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_report(i_m_tdata);
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TOLERANCE:   radius      = i_cfg_data[TOL_W-1:0];
                    CFG_NUM_OBJECTS: class_count = i_cfg_data[NOBJ_W-1:0];
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                take_request(t_mode'(i_s_tuser), i_s_tdata);
            end
        end
        o_fail_count        <= fails;
        o_pending           <= owed_reports_q.size();
        o_reports           <= seen_reports;
        o_overflow_reports  <= seen_overflow;
        o_saturated_reports <= seen_saturated;
    end

endmodule

/* sim/greedy_point_match_scoring_tb.sv */
// Testbench top for the greedy point-match scorer: clock, reset, request and report
// traffic, register writes and the verdict. Checking is done by gpms_checker.
// Depends on gpms_pkg, gpms_checker and the scorer RTL.
module greedy_point_match_scoring_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gpms_pkg::*;

    localparam int LATENCY_PAUSE  = PRED_DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int PHASES         = 8;
    localparam int COORD_MAX      = 2 ** (COORD_BITS - 1) - 1;
    localparam int COORD_MIN      = -(2 ** (COORD_BITS - 1));
    localparam int TOL_MAX        = 2 ** TOL_W - 1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    wire [OUT_DATA_W-1:0]  m_tdata;
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    int fail_count;
    int pending;
    int reports;
    int overflow_reports;
    int saturated_reports;

    // Stimulus-side view of the configuration and the idling controls.
    int cur_radius = 4588;
    int cur_classes = 2;
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    int rx_hold_req = 0;
    int requests_sent = 0;
    int reg_writes = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    greedy_point_match_scoring i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    gpms_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_s_tdata           (s_tdata),
        .i_s_tuser           (s_tuser),
        .i_s_tvalid          (s_tvalid),
        .i_s_tready          (s_tready),
        .i_m_tdata           (m_tdata),
        .i_m_tvalid          (m_tvalid),
        .i_m_tready          (m_tready),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_reports           (reports),
        .o_overflow_reports  (overflow_reports),
        .o_saturated_reports (saturated_reports)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            return $urandom_range(1, 3);
        end
        if (pick < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_point point_at(int x, int y, int z);
        t_point pt;
        pt.x = COORD_BITS'(x);
        pt.y = COORD_BITS'(y);
        pt.z = COORD_BITS'(z);
        return pt;
    endfunction

    function automatic t_point random_point();
        return point_at($urandom(), $urandom(), $urandom());
    endfunction

    // Move every axis by a random amount in [-span, span]; wraps at the field width.
    function automatic t_point jitter(t_point base, int span);
        t_point pt;
        pt = base;
        if (span > 0) begin
            pt.x = base.x + COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
            pt.y = base.y + COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
            pt.z = base.z + COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
        end
        return pt;
    endfunction

    // Ground truth placed against a stored prediction: well inside, on the rim, or loose.
    function automatic t_point truth_near(t_point target);
        t_point pt;
        int     pick;
        int     rim;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return jitter(target, cur_radius / 2);
        end
        if (pick < 75) begin
            pt  = target;
            rim = (cur_radius > 0) ? cur_radius - int'($urandom_range(0, 1)) : 0;
            if ($urandom_range(0, 1) != 0) begin
                rim = -rim;
            end
            case ($urandom_range(0, 2))
                0:       pt.x = pt.x + COORD_BITS'(rim);
                1:       pt.y = pt.y + COORD_BITS'(rim);
                default: pt.z = pt.z + COORD_BITS'(rim);
            endcase
            return pt;
        end
        return jitter(target, (cur_radius > 4194303) ? TOL_MAX : 2 * cur_radius);
    endfunction

    // Mostly classes that are counted, sometimes any class at all.
    function automatic logic [OID_W-1:0] truth_class();
        int top;
        top = (cur_classes > 256) ? 256 : cur_classes;
        if (top >= 2 && $urandom_range(0, 99) < 85) begin
            return OID_W'($urandom_range(0, top - 2));
        end
        return OID_W'($urandom());
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_request(t_mode kind, logic [OID_W-1:0] oid, t_point pt);
        int gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 99) < 30) begin
            gap = gap_length();
        end
        repeat (gap) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pt, oid};
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    // Stop offering, wait for every owed report, then let a ground-truth scan finish.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (LATENCY_PAUSE) begin
            @(negedge clk);
        end
    endtask

    task automatic write_register(t_cfg_idx idx, int value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_config(int radius, int classes);
        drain();
        write_register(CFG_TOLERANCE, radius);
        write_register(CFG_NUM_OBJECTS, classes);
        cur_radius  = radius;
        cur_classes = classes;
    endtask

    // One frame: predictions around a cluster center interleaved with ground truth.
    task automatic run_frame(int n_pred, int n_truth);
        t_point placed [$];
        t_point center;
        t_point pt;
        int     left_pred;
        int     left_truth;
        int     spread;
        center     = random_point();
        spread     = (cur_radius > 1048576) ? 4194304 : 4 * cur_radius + 16;
        left_pred  = n_pred;
        left_truth = n_truth;
        while (left_pred > 0 || left_truth > 0) begin
            if (left_pred > 0 && (left_truth == 0 || $urandom_range(0, 2) != 0)) begin
                pt = ($urandom_range(0, 9) < 6) ? jitter(center, spread) : random_point();
                send_request(MODE_PRED, OID_W'($urandom()), pt);
                placed = {placed, pt};
                left_pred--;
            end else begin
                if (placed.size() > 0 && $urandom_range(0, 99) < 85) begin
                    pt = truth_near(placed[$urandom_range(0, placed.size() - 1)]);
                end else begin
                    pt = random_point();
                end
                send_request(MODE_GT, truth_class(), pt);
                left_truth--;
            end
        end
        send_request(MODE_EOF, OID_W'($urandom()), random_point());
    endtask

    // Receiver: random stalls, plus a long hold-off on request from the stimulus.
    initial begin : report_sink
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!rx_gaps_on) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 25) begin
                    stall_left = gap_length();
                end
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("greedy_point_match_scoring_tb: no traffic for %0d cycles", WATCHDOG_LIMIT);
        $display("greedy_point_match_scoring_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int radius;
        int classes;
        int stop_at;

        repeat (10) begin
            @(negedge clk);
        end
        rst_n <= 1'b1;

        // Reset settings: rim distances, ignored class, diagonal miss, empty store.
        send_request(MODE_GT,    8'd0,   point_at(0, 0, 0));
        send_request(MODE_PRED,  8'd0,   point_at(0, 0, 0));
        send_request(MODE_PRED,  8'd255, point_at(100, 0, 0));
        send_request(MODE_GT,    8'd0,   point_at(4587, 0, 0));
        send_request(MODE_GT,    8'd0,   point_at(-4488, 0, 0));
        send_request(MODE_GT,    8'd1,   point_at(100, 0, 0));
        send_request(MODE_GT,    8'd0,   point_at(3000, 3000, 3000));
        send_request(MODE_GT,    8'd0,   point_at(100, 0, -4587));
        send_request(MODE_EOF,   8'd0,   point_at(0, 0, 0));
        send_request(MODE_CLEAR, 8'hff,  point_at(-1, -1, -1));
        send_request(MODE_PRED,  8'd0,   point_at(COORD_MIN, COORD_MAX, COORD_MIN));
        send_request(MODE_PRED,  8'd128, point_at(COORD_MAX, COORD_MIN, COORD_MAX));
        send_request(MODE_EOF,   8'd0,   point_at(0, 0, 0));

        // Widest radius, classes 0 to 254 counted: opposite corners never match.
        set_config(TOL_MAX, 256);
        send_request(MODE_PRED,  8'd7,   point_at(COORD_MIN, COORD_MIN, COORD_MIN));
        send_request(MODE_PRED,  8'd200, point_at(COORD_MAX, COORD_MAX, COORD_MAX));
        send_request(MODE_GT,    8'd255, point_at(COORD_MIN, COORD_MIN, COORD_MIN));
        send_request(MODE_GT,    8'd254, point_at(0, 0, 0));
        send_request(MODE_GT,    8'd0,   point_at(-8388000, COORD_MIN, COORD_MIN));
        send_request(MODE_EOF,   8'd0,   point_at(0, 0, 0));

        // Zero radius: even an exact hit is a miss.
        set_config(0, 3);
        send_request(MODE_PRED,  8'd0,   point_at(5, 5, 5));
        send_request(MODE_GT,    8'd0,   point_at(5, 5, 5));
        send_request(MODE_EOF,   8'd0,   point_at(0, 0, 0));

        // Random frames under a range of register settings.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin radius = 4588;                          classes = 2;   end
                1: begin radius = $urandom_range(1, 64);         classes = 1;   end
                2: begin radius = TOL_MAX;                       classes = 256; end
                3: begin radius = $urandom_range(1000, 200000);  classes = $urandom_range(3, 255); end
                4: begin radius = 0;                             classes = 2;   end
                5: begin radius = $urandom_range(0, TOL_MAX);    classes = 511; end
                6: begin radius = $urandom_range(100, 20000);    classes = 0;   end
                default: begin
                    radius  = $urandom_range(2000, 60000);
                    classes = $urandom_range(257, 510);
                end
            endcase
            set_config(radius, classes);
            tx_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            rx_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            stop_at = requests_sent + RANDOM_ITEMS / PHASES;

            // A store that fills and overflows, then one filled exactly.
            if (phase == 2) begin
                run_frame(PRED_DEPTH + $urandom_range(1, 6), $urandom_range(4, 12));
            end
            if (phase == 5) begin
                run_frame(PRED_DEPTH, $urandom_range(4, 12));
            end

            // Receiver holds off while short frames keep coming, so the input backs up.
            if (phase == 3) begin
                rx_hold_req = 600;
                repeat (6) begin
                    run_frame(1, 1);
                end
            end

            while (requests_sent < stop_at) begin
                if ($urandom_range(0, 99) < 10) begin
                    send_request(t_mode'($urandom_range(0, 3)), OID_W'($urandom()),
                                 random_point());
                end else if ($urandom_range(0, 99) < 2) begin
                    run_frame($urandom_range(40, PRED_DEPTH), $urandom_range(2, 10));
                end else begin
                    run_frame($urandom_range(0, 12), $urandom_range(0, 12));
                end
            end
        end

        drain();
        $display("greedy_point_match_scoring_tb: %0d requests, %0d frame reports, %0d writes",
                 requests_sent, reports, reg_writes);
        $display("greedy_point_match_scoring_tb: %0d reports with dropped predictions, %0d %s",
                 overflow_reports, saturated_reports, "with a saturated miss count");
        if (fail_count == 0 && pending == 0) begin
            $display("greedy_point_match_scoring_tb: done, clean");
        end else begin
            $display("greedy_point_match_scoring_tb: done, errors");
        end
        $finish;
    end

endmodule

/* greedy_point_match_scoring.f */
rtl/gpms_pkg.sv
rtl/gpms_ctrl.sv
rtl/gpms_datapath.sv
rtl/greedy_point_match_scoring.sv
sim/gpms_checker.sv
sim/greedy_point_match_scoring_tb.sv
